FILE: rtl/i2c_master_byte_engine_top_macros.svh
// Assertion macros used by the bound checker module.
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define I2CMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cmb: assertion failed");

// Next-cycle implication, off while reset is held.
`define I2CMB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cmb: assertion failed");

// Implication that is checked through reset as well.
`define I2CMB_ASSERT_ALW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("i2cmb: assertion failed");

`endif

FILE: rtl/i2cmb_pkg.sv
package i2cmb_pkg;

  localparam int DELAY_BITS_DEF = 16;
  localparam int TICK_W         = 16;
  localparam logic [TICK_W-1:0] TICK_RST = 16'd10;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_HIGH   = 2'd0,
    REG_LOW    = 2'd1,
    REG_COARSE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_UNINIT  = 3'b001,
    PH_STOPPED = 3'b010,
    PH_STARTED = 3'b100
  } phase_t;

  // Control state of the engine.
  typedef struct packed {
    phase_t     phase;
    cmd_t       act_cmd;
    logic       busy;
    logic [2:0] step;
    logic [3:0] bit_cnt;
    logic       scl;
    logic       sda_low;
    logic       nack;
    logic       last;
    logic       done;
  } ctl_t;

  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic [TICK_W-1:0] coarse_ticks;
  } timing_t;

endpackage

FILE: rtl/i2cmb_if.sv
interface i2cmb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] command;
  logic [7:0] tx_byte;
  logic       last_read;
  logic       sda_in;

  modport source (output valid, cmd_valid, command, tx_byte, last_read, sda_in, input ready);
  modport sink   (input valid, cmd_valid, command, tx_byte, last_read, sda_in, output ready);
endinterface

interface i2cmb_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_pull_low;
  logic       ready_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack;
  logic       bus_started;

  modport source (output valid, scl_out, sda_pull_low, ready_res, done_res, rx_byte, nack,
                  bus_started, input ready);
  modport sink   (input valid, scl_out, sda_pull_low, ready_res, done_res, rx_byte, nack,
                  bus_started, output ready);
endinterface

interface i2cmb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/i2cmb_step.sv
// Next-state logic for one bus tick.
module i2cmb_step #(
  parameter int DELAY_BITS = i2cmb_pkg::DELAY_BITS_DEF
) (
  input  i2cmb_pkg::ctl_t    ctl_cur,
  input  logic [DELAY_BITS-1:0] delay_cur,
  input  logic [7:0]         shift_cur,
  input  logic [7:0]         rx_cur,
  input  i2cmb_pkg::timing_t tim,
  input  logic               cmd_valid,
  input  logic [1:0]         command,
  input  logic [7:0]         tx_byte,
  input  logic               last_read,
  input  logic               sda_in,
  output i2cmb_pkg::ctl_t    ctl_nxt,
  output logic [DELAY_BITS-1:0] delay_nxt,
  output logic [7:0]         shift_nxt,
  output logic [7:0]         rx_nxt
);
  import i2cmb_pkg::*;

  localparam logic [32:0] LIM = (33'd1 << DELAY_BITS) - 33'd1;

  // Zero counts as one tick; values past the counter saturate.
  function automatic logic [DELAY_BITS-1:0] wait_of(input logic [TICK_W-1:0] v);
    logic [32:0] w;
    w = {17'd0, v};
    if (w == 33'd0) w = 33'd1;
    if (w > LIM) w = LIM;
    return w[DELAY_BITS-1:0];
  endfunction

  logic [3:0] bit_inc;
  logic [7:0] shl;

  assign bit_inc = ctl_cur.bit_cnt + 4'd1;
  assign shl     = {shift_cur[6:0], 1'b0};

  always_comb begin
    ctl_nxt      = ctl_cur;
    ctl_nxt.done = 1'b0;
    delay_nxt    = delay_cur;
    shift_nxt    = shift_cur;
    rx_nxt       = rx_cur;

    if (ctl_cur.busy) begin
      if (delay_cur > DELAY_BITS'(1)) begin
        delay_nxt = delay_cur - DELAY_BITS'(1);
      end else begin
        unique case (ctl_cur.act_cmd)
          CMD_START: begin
            if (ctl_cur.step <= 3'd3) begin
              case (ctl_cur.step)
                3'd0:    ctl_nxt.sda_low = 1'b0;
                3'd1:    ctl_nxt.scl     = 1'b1;
                3'd2:    ctl_nxt.sda_low = 1'b1;
                default: ctl_nxt.scl     = 1'b0;
              endcase
              ctl_nxt.step = ctl_cur.step + 3'd1;
              delay_nxt    = wait_of(tim.coarse_ticks);
            end else begin
              ctl_nxt.phase = PH_STARTED;
              ctl_nxt.busy  = 1'b0;
              ctl_nxt.done  = 1'b1;
            end
          end
          CMD_STOP: begin
            if (ctl_cur.step <= 3'd2) begin
              case (ctl_cur.step)
                3'd0:    ctl_nxt.sda_low = 1'b1;
                3'd1:    ctl_nxt.scl     = 1'b1;
                default: ctl_nxt.sda_low = 1'b0;
              endcase
              ctl_nxt.step = ctl_cur.step + 3'd1;
              delay_nxt    = wait_of(tim.coarse_ticks);
            end else begin
              ctl_nxt.phase = PH_STOPPED;
              ctl_nxt.busy  = 1'b0;
              ctl_nxt.done  = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (ctl_cur.step == 3'd0) begin
              ctl_nxt.sda_low = ~shift_cur[7];
              ctl_nxt.step    = 3'd1;
              delay_nxt       = wait_of(tim.low_ticks);
            end else if (ctl_cur.step == 3'd1) begin
              ctl_nxt.scl  = 1'b1;
              ctl_nxt.step = 3'd2;
              delay_nxt    = wait_of(tim.high_ticks);
            end else if (ctl_cur.bit_cnt >= 4'd8) begin
              // ACK bit slot
              ctl_nxt.nack = sda_in;
              ctl_nxt.scl  = 1'b0;
              ctl_nxt.busy = 1'b0;
              ctl_nxt.done = 1'b1;
            end else begin
              ctl_nxt.scl     = 1'b0;
              ctl_nxt.bit_cnt = bit_inc;
              shift_nxt       = shl;
              ctl_nxt.sda_low = (bit_inc < 4'd8) ? ~shl[7] : 1'b0;
              ctl_nxt.step    = 3'd1;
              delay_nxt       = wait_of(tim.low_ticks);
            end
          end
          CMD_READ: begin
            if (ctl_cur.step <= 3'd1) begin
              if (ctl_cur.bit_cnt >= 4'd8) ctl_nxt.sda_low = ~ctl_cur.last;
              ctl_nxt.scl  = 1'b1;
              ctl_nxt.step = 3'd2;
              delay_nxt    = wait_of(tim.high_ticks);
            end else if (ctl_cur.step == 3'd2) begin
              if (ctl_cur.bit_cnt < 4'd8) begin
                shift_nxt       = {shift_cur[6:0], sda_in};
                ctl_nxt.bit_cnt = bit_inc;
                ctl_nxt.step    = 3'd1;
              end else begin
                ctl_nxt.step = 3'd3;
              end
              ctl_nxt.scl = 1'b0;
              delay_nxt   = wait_of(tim.low_ticks);
            end else begin
              rx_nxt       = shift_cur;
              ctl_nxt.busy = 1'b0;
              ctl_nxt.done = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd_valid) begin
      ctl_nxt.act_cmd = cmd_t'(command);
      ctl_nxt.step    = 3'd0;
      ctl_nxt.bit_cnt = 4'd0;
      unique case (cmd_t'(command))
        CMD_START: begin
          if (ctl_cur.phase != PH_STARTED) begin
            ctl_nxt.busy = 1'b1;
            delay_nxt    = wait_of(tim.coarse_ticks);
          end else begin
            ctl_nxt.done = 1'b1;
          end
        end
        CMD_STOP: begin
          if (ctl_cur.phase == PH_STARTED) begin
            ctl_nxt.busy = 1'b1;
            delay_nxt    = wait_of(tim.coarse_ticks);
          end else begin
            ctl_nxt.done = 1'b1;
          end
        end
        CMD_WRITE: begin
          shift_nxt    = tx_byte;
          ctl_nxt.busy = 1'b1;
          delay_nxt    = wait_of(tim.coarse_ticks);
        end
        CMD_READ: begin
          ctl_nxt.sda_low = 1'b0;
          shift_nxt       = 8'd0;
          ctl_nxt.last    = last_read;
          ctl_nxt.step    = 3'd1;
          ctl_nxt.busy    = 1'b1;
          delay_nxt       = wait_of(tim.coarse_ticks);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/i2c_master_byte_engine_top.sv
// Channel  | Dir | Modport | Payload
// in_bus   | in  | sink    | cmd_valid, command, tx_byte, last_read, sda_in (one bus tick)
// out_bus  | out | source  | scl_out, sda_pull_low, ready_res, done_res, rx_byte, nack,
//          |     |         | bus_started (state after the tick)
// cfg_bus  | in  | sink    | index (0 high, 1 low, 2 coarse ticks), data[15:0]
//
// One tick per clock: a transaction on in_bus is taken every cycle that the
// output register is empty or being drained, and its result shows in the next cycle.
// The rate is set by the single registered pass of the step logic; in_bus.ready
// drops only while a result sits in the output register and out_bus.ready is low.
// rst_n is synchronous, active low; the timing registers return to 10 ticks.
// cfg_bus is always ready; writes to an index past the list are dropped.
module i2c_master_byte_engine_top #(
  parameter int DELAY_BITS = i2cmb_pkg::DELAY_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  i2cmb_in_if.sink   in_bus,
  i2cmb_out_if.source out_bus,
  i2cmb_cfg_if.sink  cfg_bus
);
  import i2cmb_pkg::*;

  // Engine state, advanced once per accepted tick
  ctl_t                  ctl_r;
  logic [DELAY_BITS-1:0] delay_r;
  logic [7:0]            shift_r;
  logic [7:0]            rx_r;
  timing_t               tim_r;

  ctl_t                  ctl_nxt;
  logic [DELAY_BITS-1:0] delay_nxt;
  logic [7:0]            shift_nxt;
  logic [7:0]            rx_nxt;

  // Output register
  logic       out_valid_r;
  logic       scl_r;
  logic       sda_low_r;
  logic       rdy_res_r;
  logic       done_r;
  logic [7:0] rx_out_r;
  logic       nack_r;
  logic       started_r;

  logic in_acc;

  // Take a new tick whenever the result slot frees up this cycle.
  assign in_bus.ready = ~out_valid_r | out_bus.ready;
  assign in_acc       = in_bus.valid & in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  i2cmb_step #(
    .DELAY_BITS (DELAY_BITS)
  ) u_step (
    .ctl_cur   (ctl_r),
    .delay_cur (delay_r),
    .shift_cur (shift_r),
    .rx_cur    (rx_r),
    .tim       (tim_r),
    .cmd_valid (in_bus.cmd_valid),
    .command   (in_bus.command),
    .tx_byte   (in_bus.tx_byte),
    .last_read (in_bus.last_read),
    .sda_in    (in_bus.sda_in),
    .ctl_nxt   (ctl_nxt),
    .delay_nxt (delay_nxt),
    .shift_nxt (shift_nxt),
    .rx_nxt    (rx_nxt)
  );

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tim_r.high_ticks   <= TICK_RST;
      tim_r.low_ticks    <= TICK_RST;
      tim_r.coarse_ticks <= TICK_RST;
    end else if (cfg_bus.valid) begin
      unique case (reg_idx_t'(cfg_bus.index))
        REG_HIGH:   tim_r.high_ticks   <= cfg_bus.data;
        REG_LOW:    tim_r.low_ticks    <= cfg_bus.data;
        REG_COARSE: tim_r.coarse_ticks <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // Engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase   <= PH_UNINIT;
      ctl_r.act_cmd <= CMD_START;
      ctl_r.busy    <= 1'b0;
      ctl_r.step    <= 3'd0;
      ctl_r.bit_cnt <= 4'd0;
      ctl_r.scl     <= 1'b1;
      ctl_r.sda_low <= 1'b0;
      ctl_r.nack    <= 1'b0;
      ctl_r.last    <= 1'b0;
      ctl_r.done    <= 1'b0;
      delay_r       <= '0;
      shift_r       <= 8'd0;
      rx_r          <= 8'd0;
    end else if (in_acc) begin
      ctl_r   <= ctl_nxt;
      delay_r <= delay_nxt;
      shift_r <= shift_nxt;
      rx_r    <= rx_nxt;
    end
  end

  // Result slot: valid flag under reset, payload loads with each tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_acc | (out_valid_r & ~out_bus.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      scl_r     <= ctl_nxt.scl;
      sda_low_r <= ctl_nxt.sda_low;
      rdy_res_r <= ~ctl_nxt.busy;
      done_r    <= ctl_nxt.done;
      rx_out_r  <= rx_nxt;
      nack_r    <= ctl_nxt.nack;
      started_r <= (ctl_nxt.phase == PH_STARTED);
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.scl_out      = scl_r;
  assign out_bus.sda_pull_low = sda_low_r;
  assign out_bus.ready_res    = rdy_res_r;
  assign out_bus.done_res     = done_r;
  assign out_bus.rx_byte      = rx_out_r;
  assign out_bus.nack         = nack_r;
  assign out_bus.bus_started  = started_r;

endmodule

FILE: rtl/i2cmb_chk.sv
`include "i2c_master_byte_engine_top_macros.svh"

module i2cmb_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_ready_res,
  input logic out_done_res
);

  // Input stalls only behind a held result.
  `I2CMB_ASSERT_IMP(a_stall_cause, clk, rst_n, in_valid && !in_ready, out_valid && !out_ready)
  // Every tick yields a result next cycle.
  `I2CMB_ASSERT_NXT(a_tick_result, clk, rst_n, in_valid && in_ready, out_valid)
  // A finishing command leaves the engine idle.
  `I2CMB_ASSERT_IMP(a_done_idle, clk, rst_n, out_valid && out_done_res, out_ready_res)
  // Nothing shows right after reset.
  `I2CMB_ASSERT_ALW(a_rst_empty, clk, $past(!rst_n), !out_valid)

endmodule

bind i2c_master_byte_engine_top i2cmb_chk u_i2cmb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_ready_res (out_bus.ready_res),
  .out_done_res  (out_bus.done_res)
);

FILE: verif/i2cmb_checker.sv
`timescale 1ns / 100ps

// Watches the tick, result and register channels, keeps a tick-by-tick model
// of the I2C byte engine and compares every result with its prediction.
module i2cmb_checker #(
  parameter int DELAY_BITS = i2cmb_pkg::DELAY_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  i2cmb_in_if   in_bus,
  i2cmb_out_if  out_bus,
  i2cmb_cfg_if  cfg_bus,
  output int    errors,
  output int    pending,
  output logic  engine_busy
);
  import i2cmb_pkg::*;

  localparam int BYTE_BITS = 8;

  typedef struct packed {
    logic       cmd_valid;
    cmd_t       cmd;
    logic [7:0] tx;
    logic       last;
    logic       sda;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       rdy;
    logic       done;
    logic [7:0] rx;
    logic       nack;
    logic       started;
  } bus_view_t;

  timing_t    tmg;
  phase_t     phase;
  cmd_t       cur_cmd;
  logic       busy;
  logic [2:0] step;
  logic [3:0] nbits;
  logic [31:0] wait_cnt;
  logic [7:0] shreg;
  logic       scl;
  logic       sda_low;
  logic       nack_bit;
  logic       last_flag;
  logic       done_pulse;
  logic [7:0] rx_hold;

  bus_view_t  expected_views[$];
  int         err_count = 0;

  assign errors = err_count;

  task automatic reset_model();
    tmg = '{TICK_RST, TICK_RST, TICK_RST};
    phase = PH_UNINIT;
    cur_cmd = CMD_START;
    busy = 1'b0;
    step = '0;
    nbits = '0;
    wait_cnt = '0;
    shreg = '0;
    scl = 1'b1;
    sda_low = 1'b0;
    nack_bit = 1'b0;
    last_flag = 1'b0;
    done_pulse = 1'b0;
    rx_hold = '0;
  endtask

  // zero counts as one tick, anything past the counter saturates
  task automatic load_wait(input logic [15:0] ticks);
    longint lim;
    lim = (64'd1 << DELAY_BITS) - 1;
    wait_cnt = (ticks == 16'd0) ? 32'd1 : 32'(ticks);
    if (longint'(wait_cnt) > lim) wait_cnt = 32'(lim);
  endtask

  task automatic end_command();
    busy = 1'b0;
    done_pulse = 1'b1;
  endtask

  // one pin step of the running command, taken when its wait runs out
  task automatic advance(input logic sda);
    case (cur_cmd)
      CMD_START: begin
        if (step > 3'd3) begin
          phase = PH_STARTED;
          end_command();
        end else begin
          case (step)
            3'd0: sda_low = 1'b0;
            3'd1: scl = 1'b1;
            3'd2: sda_low = 1'b1;
            default: scl = 1'b0;
          endcase
          step = step + 3'd1;
          load_wait(tmg.coarse_ticks);
        end
      end
      CMD_STOP: begin
        if (step > 3'd2) begin
          phase = PH_STOPPED;
          end_command();
        end else begin
          case (step)
            3'd0: sda_low = 1'b1;
            3'd1: scl = 1'b1;
            default: sda_low = 1'b0;
          endcase
          step = step + 3'd1;
          load_wait(tmg.coarse_ticks);
        end
      end
      CMD_WRITE: begin
        if (step == 3'd0) begin
          sda_low = !shreg[7];
          step = 3'd1;
          load_wait(tmg.low_ticks);
        end else if (step == 3'd1) begin
          scl = 1'b1;
          step = 3'd2;
          load_wait(tmg.high_ticks);
        end else if (nbits >= BYTE_BITS) begin
          // ack slot: SDA level is the slave's answer
          nack_bit = sda;
          scl = 1'b0;
          end_command();
        end else begin
          scl = 1'b0;
          nbits = nbits + 4'd1;
          shreg = shreg << 1;
          sda_low = (nbits < BYTE_BITS) ? !shreg[7] : 1'b0;
          step = 3'd1;
          load_wait(tmg.low_ticks);
        end
      end
      default: begin
        if (step <= 3'd1) begin
          if (nbits >= BYTE_BITS) sda_low = !last_flag;
          scl = 1'b1;
          step = 3'd2;
          load_wait(tmg.high_ticks);
        end else if (step == 3'd2) begin
          if (nbits < BYTE_BITS) begin
            shreg = {shreg[6:0], sda};
            nbits = nbits + 4'd1;
            scl = 1'b0;
            step = 3'd1;
          end else begin
            scl = 1'b0;
            step = 3'd3;
          end
          load_wait(tmg.low_ticks);
        end else begin
          rx_hold = shreg;
          end_command();
        end
      end
    endcase
  endtask

  task automatic bus_tick(input tick_t t, output bus_view_t v);
    done_pulse = 1'b0;
    if (busy) begin
      if (wait_cnt > 32'd1) wait_cnt = wait_cnt - 32'd1;
      else advance(t.sda);
    end else if (t.cmd_valid) begin
      cur_cmd = t.cmd;
      step = '0;
      nbits = '0;
      case (t.cmd)
        CMD_START: begin
          if (phase != PH_STARTED) begin
            busy = 1'b1;
            load_wait(tmg.coarse_ticks);
          end else begin
            done_pulse = 1'b1;
          end
        end
        CMD_STOP: begin
          if (phase == PH_STARTED) begin
            busy = 1'b1;
            load_wait(tmg.coarse_ticks);
          end else begin
            done_pulse = 1'b1;
          end
        end
        CMD_WRITE: begin
          shreg = t.tx;
          busy = 1'b1;
          load_wait(tmg.coarse_ticks);
        end
        default: begin
          sda_low = 1'b0;
          shreg = '0;
          last_flag = t.last;
          step = 3'd1;
          busy = 1'b1;
          load_wait(tmg.coarse_ticks);
        end
      endcase
    end
    v.scl = scl;
    v.sda_low = sda_low;
    v.rdy = !busy;
    v.done = done_pulse;
    v.rx = rx_hold;
    v.nack = nack_bit;
    v.started = (phase == PH_STARTED);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    tick_t     t;
    bus_view_t v;
    bus_view_t w;
    if (!rst_n) begin
      reset_model();
      expected_views.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_HIGH:   tmg.high_ticks = cfg_bus.data;
          REG_LOW:    tmg.low_ticks = cfg_bus.data;
          REG_COARSE: tmg.coarse_ticks = cfg_bus.data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        t = '{in_bus.cmd_valid, cmd_t'(in_bus.command), in_bus.tx_byte,
              in_bus.last_read, in_bus.sda_in};
        bus_tick(t, v);
        expected_views.push_back(v);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_views.size() == 0) begin
          $error("result transaction with no tick outstanding");
          err_count++;
        end else begin
          w = expected_views.pop_front();
          check_field("scl_out", 8'(w.scl), 8'(out_bus.scl_out));
          check_field("sda_pull_low", 8'(w.sda_low), 8'(out_bus.sda_pull_low));
          check_field("ready_res", 8'(w.rdy), 8'(out_bus.ready_res));
          check_field("done_res", 8'(w.done), 8'(out_bus.done_res));
          check_field("rx_byte", w.rx, out_bus.rx_byte);
          check_field("nack", 8'(w.nack), 8'(out_bus.nack));
          check_field("bus_started", 8'(w.started), 8'(out_bus.bus_started));
        end
      end
    end
    pending <= expected_views.size();
    engine_busy <= busy;
  end

endmodule

FILE: verif/i2c_master_byte_engine_top_test.sv
`timescale 1ns / 100ps

module i2c_master_byte_engine_top_test;
  import i2cmb_pkg::*;

  // No transaction on any channel for this long means the block is hung.
  // The longest legal quiet stretch is the forced receiver hold below.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  // Index past the register list; the block must drop the write.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  i2cmb_in_if  in_bus();
  i2cmb_out_if out_bus();
  i2cmb_cfg_if cfg_bus();

  int   errors;
  int   pending;
  logic engine_busy;

  // Idle rates in percent, changed between traffic phases.
  int   sender_idle = 0;
  int   receiver_idle = 0;
  // Asks the receiver process for one long hold-off.
  bit   hold_req = 1'b0;
  int   quiet_cycles = 0;
  // Tick transactions accepted so far.
  int   ticks_sent = 0;

  i2c_master_byte_engine_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  i2cmb_checker bus_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_bus     (cfg_bus),
    .errors      (errors),
    .pending     (pending),
    .engine_busy (engine_busy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, plus one long hold on request so the
  // output register fills and the block has to stall its tick input.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= receiver_idle);
      end
    end
  end

  // Watchdog: counts cycles with no transaction anywhere.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One bus tick on in_bus. SDA is random every tick, so the ACK slot and
  // the read data bits see both levels.
  task automatic send_tick(input logic cv, input cmd_t c, input logic [7:0] tx,
                           input logic lr);
    while ($urandom_range(99) < sender_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.cmd_valid <= cv;
    in_bus.command   <= c;
    in_bus.tx_byte   <= tx;
    in_bus.last_read <= lr;
    in_bus.sda_in    <= 1'($urandom_range(1));
    do @(posedge clk); while (!in_bus.ready);
    ticks_sent++;
  endtask

  // Keep ticking until the engine is free again. engine_busy is a registered
  // copy of the model flag, so it is read after a further tick. noise_pct offers stray
  // commands meanwhile; the engine must ignore those while busy.
  task automatic wait_idle(input int noise_pct);
    logic nz;
    do begin
      nz = ($urandom_range(99) < noise_pct);
      send_tick(nz, cmd_t'($urandom_range(3)), rand_byte(), 1'($urandom_range(1)));
    end while (engine_busy);
  endtask

  task automatic run_command(input cmd_t c, input logic [7:0] tx, input logic lr,
                             input int noise_pct);
    send_tick(1'b1, c, tx, lr);
    wait_idle(noise_pct);
  endtask

  // Stop offering ticks and let every result drain. Registers are only
  // written after this.
  task automatic quiesce();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_timing(input logic [15:0] hi, input logic [15:0] lo,
                            input logic [15:0] crs);
    reg_idx_t    idx[3];
    logic [15:0] vals[3];
    idx  = '{REG_HIGH, REG_LOW, REG_COARSE};
    vals = '{hi, lo, crs};
    for (int i = 0; i < 3; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= vals[i];
      do @(posedge clk); while (!cfg_bus.ready);
    end
    // stray write past the register list, must change nothing
    cfg_bus.index <= REG_UNUSED;
    cfg_bus.data  <= 16'($urandom_range(16'hFFFF));
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Mostly well-formed transfers: START, a byte write or read or two, STOP.
  // Sometimes the STOP or START is left out, or a stray command slips in,
  // and noise commands are offered while the engine is busy. Runs until
  // about budget ticks have gone in.
  task automatic random_traffic(input int budget);
    int goal;
    int n;
    goal = ticks_sent + budget;
    while (ticks_sent < goal) begin
      if ($urandom_range(9) != 0) run_command(CMD_START, rand_byte(), 1'b0, 8);
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1)) begin
          run_command(CMD_WRITE, rand_byte(), 1'($urandom_range(1)), 8);
        end else begin
          // last byte of a run always answers NACK, other bytes now and then
          run_command(CMD_READ, rand_byte(), (i == n - 1) || ($urandom_range(3) == 0), 8);
        end
        if ($urandom_range(19) == 0)
          run_command(cmd_t'($urandom_range(3)), rand_byte(), 1'($urandom_range(1)), 8);
        if (ticks_sent >= goal) break;
      end
      if ($urandom_range(6) != 0) run_command(CMD_STOP, rand_byte(), 1'b0, 8);
      repeat ($urandom_range(3)) send_tick(1'b0, CMD_START, rand_byte(), 1'b0);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.cmd_valid <= 1'b0;
    in_bus.command   <= CMD_START;
    in_bus.tx_byte   <= 8'h00;
    in_bus.last_read <= 1'b0;
    in_bus.sda_in    <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= REG_HIGH;
    cfg_bus.data     <= 16'h0000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed: reset timing (10 ticks everywhere), no idling ----
    run_command(CMD_STOP, 8'h00, 1'b0, 0);       // stop on a never-started bus: no-op
    run_command(CMD_START, 8'h00, 1'b0, 0);      // start from the uninitialised bus

    // ---- directed: all timing registers zero, each wait is one tick ----
    quiesce();
    set_timing(16'h0000, 16'h0000, 16'h0000);
    // a second command right behind a write lands while busy and is dropped
    send_tick(1'b1, CMD_WRITE, 8'hFF, 1'b0);
    send_tick(1'b1, CMD_READ, 8'h00, 1'b1);
    wait_idle(0);
    run_command(CMD_WRITE, 8'h00, 1'b0, 0);
    run_command(CMD_READ, 8'h00, 1'b0, 0);       // ACK: SDA stays pulled low after
    run_command(CMD_READ, 8'hFF, 1'b1, 0);       // last byte, NACK
    run_command(CMD_START, 8'h00, 1'b0, 0);      // already started: done at once
    run_command(CMD_STOP, 8'h00, 1'b0, 0);
    run_command(CMD_STOP, 8'h00, 1'b0, 0);       // already stopped: done at once
    run_command(CMD_WRITE, 8'hA5, 1'b0, 0);      // byte traffic on a stopped bus
    run_command(CMD_READ, 8'h00, 1'b0, 0);
    run_command(CMD_START, 8'h00, 1'b0, 0);      // start from stopped

    // ---- random: sender idles a little, receiver a lot, one long hold ----
    quiesce();
    sender_idle = 21;
    receiver_idle = 52;
    set_timing(16'($urandom_range(1, 2)), 16'($urandom_range(1, 2)),
               16'($urandom_range(1, 2)));
    hold_req = 1'b1;
    random_traffic(50);

    // ---- random: roles swapped, zero timing values allowed ----
    quiesce();
    sender_idle = 52;
    receiver_idle = 21;
    set_timing(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
               16'($urandom_range(0, 2)));
    random_traffic(50);

    // ---- random: no idling at all ----
    quiesce();
    sender_idle = 0;
    receiver_idle = 0;
    set_timing(16'($urandom_range(1, 2)), 16'($urandom_range(1, 2)),
               16'($urandom_range(1, 2)));
    random_traffic(60);

    // drain, then idle on to catch any stray result
    quiesce();
    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/i2cmb_pkg.sv
rtl/i2cmb_if.sv
rtl/i2cmb_step.sv
rtl/i2c_master_byte_engine_top.sv
rtl/i2cmb_chk.sv
verif/i2cmb_checker.sv
verif/i2c_master_byte_engine_top_test.sv
